// ===== rtl/infix_to_postfix_converter_core_macros.svh =====
// Assertion macros for the converter. Each macro expects clk and arst_n in scope.
`ifndef INFIX_TO_POSTFIX_CONVERTER_CORE_MACROS_SVH
`define INFIX_TO_POSTFIX_CONVERTER_CORE_MACROS_SVH

`ifndef ASSERT_OFF

`define ITPC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`define ITPC_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define ITPC_ASSERT_IMP(lbl, ante, cons, msg)

`define ITPC_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

// ===== rtl/itpc_pkg.sv =====
package itpc_pkg;

	localparam int STACK_DEPTH_DEF = 16;

	typedef logic [2:0] op_code_t;

	localparam op_code_t OP_LPAREN = 3'd0;
	localparam op_code_t OP_ADD    = 3'd1;
	localparam op_code_t OP_SUB    = 3'd2;
	localparam op_code_t OP_MUL    = 3'd3;
	localparam op_code_t OP_DIV    = 3'd4;
	localparam op_code_t OP_POW    = 3'd5;

	typedef logic [1:0] err_t;

	localparam err_t ERR_NONE            = 2'd0;
	localparam err_t ERR_OVERFLOW        = 2'd1;
	localparam err_t ERR_UNMATCHED_CLOSE = 2'd2;
	localparam err_t ERR_UNMATCHED_OPEN  = 2'd3;

	typedef logic [1:0] level_t;

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_MUL    = 8'h2A;
	localparam logic [7:0] CH_ADD    = 8'h2B;
	localparam logic [7:0] CH_SUB    = 8'h2D;
	localparam logic [7:0] CH_DIV    = 8'h2F;
	localparam logic [7:0] CH_POW    = 8'h5E;

	typedef enum logic [1:0] {
		CLS_OPERAND,
		CLS_OPERATOR,
		CLS_LPAREN,
		CLS_RPAREN
	} char_class_t;

	function automatic char_class_t char_class(input logic [7:0] c);
		char_class_t r;
		case (c)
			CH_ADD, CH_SUB, CH_MUL, CH_DIV, CH_POW: r = CLS_OPERATOR;
			CH_LPAREN: r = CLS_LPAREN;
			CH_RPAREN: r = CLS_RPAREN;
			default: r = CLS_OPERAND;
		endcase
		return r;
	endfunction

	function automatic op_code_t char_op(input logic [7:0] c);
		op_code_t r;
		case (c)
			CH_ADD: r = OP_ADD;
			CH_SUB: r = OP_SUB;
			CH_MUL: r = OP_MUL;
			CH_DIV: r = OP_DIV;
			CH_POW: r = OP_POW;
			default: r = OP_LPAREN;
		endcase
		return r;
	endfunction

	function automatic level_t op_level(input op_code_t op);
		level_t r;
		case (op)
			OP_ADD, OP_SUB: r = 2'd1;
			OP_MUL, OP_DIV: r = 2'd2;
			OP_POW: r = 2'd3;
			default: r = 2'd0;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] op_symbol(input op_code_t op);
		logic [7:0] r;
		case (op)
			OP_LPAREN: r = CH_LPAREN;
			OP_ADD: r = CH_ADD;
			OP_SUB: r = CH_SUB;
			OP_MUL: r = CH_MUL;
			OP_DIV: r = CH_DIV;
			OP_POW: r = CH_POW;
			default: r = CH_NUL;
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/itpc_in_if.sv =====
interface itpc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_char;
	logic       end_of_expr;

	modport source (output valid, output in_char, output end_of_expr, input ready);
	modport sink (input valid, input in_char, input end_of_expr, output ready);
endinterface

// ===== rtl/itpc_out_if.sv =====
interface itpc_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_char;
	logic       last;
	logic [1:0] error;

	modport source (output valid, output out_char, output last, output error, input ready);
	modport sink (input valid, input out_char, input last, input error, output ready);
endinterface

// ===== rtl/itpc_ram.sv =====
module itpc_ram #(
	parameter int WIDTH = 3,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// ===== rtl/infix_to_postfix_converter_core.sv =====
// Channel   Direction  Transaction payload
// infix     in         in_char[7:0], end_of_expr
// postfix   out        out_char[7:0], last, error[1:0]
//
// An operand character passes the decode, end and finish states before input is ready again.
// Every stack entry examined adds a stack RAM read state and a compare state; a push adds
// a push state, and each check that finds the stack empty adds a read state.
// The single-port-read operator stack RAM and the pop loop around it set this sequence.
// Reset clears the sequencer, the stack count and the error flag; the stack needs no clearing.
// A stalled output holds the sequencer wherever it has a result to hand over.
`include "infix_to_postfix_converter_core_macros.svh"

module infix_to_postfix_converter_core #(
	parameter int STACK_DEPTH = itpc_pkg::STACK_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	itpc_in_if.sink     infix,
	itpc_out_if.source  postfix
);
	import itpc_pkg::*;

	localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
	localparam int ADDR_W = $clog2(STACK_DEPTH);

	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_DECODE = 7'b0000010,
		S_READ   = 7'b0000100,
		S_CMP    = 7'b0001000,
		S_PUSH   = 7'b0010000,
		S_END    = 7'b0100000,
		S_FIN    = 7'b1000000
	} state_t;

	typedef enum logic [1:0] {
		MODE_OPERATOR,
		MODE_CLOSE,
		MODE_FLUSH
	} pop_mode_t;

	state_t     state_q, state_d;
	pop_mode_t  mode_q, mode_d;
	logic [CNT_W-1:0] count_q, count_d;
	err_t       err_seen_q, err_seen_d;
	logic [7:0] char_q;
	logic       end_q;

	logic       pend_vq;
	logic [7:0] pend_char_q;
	err_t       pend_err_q;

	logic       out_vq;
	logic [7:0] out_char_q;
	logic       out_last_q;
	err_t       out_err_q;

	logic       emit;
	logic [7:0] emit_char;
	err_t       emit_err;
	logic       fin_load;
	logic       can_out;
	logic       stall;
	logic       to_out;

	logic              ram_we;
	logic              ram_re;
	logic [ADDR_W-1:0] ram_waddr;
	logic [ADDR_W-1:0] ram_raddr;
	op_code_t          ram_rdata;
	op_code_t          cur_op;
	level_t            cur_level;
	logic [CNT_W-1:0]  count_dec;

	assign cur_op    = char_op(char_q);
	assign cur_level = op_level(cur_op);
	assign count_dec = count_q - CNT_W'(1);
	assign ram_waddr = count_q[ADDR_W-1:0];
	assign ram_raddr = count_dec[ADDR_W-1:0];

	assign can_out  = !out_vq || postfix.ready;
	assign fin_load = (state_q == S_FIN) && (pend_vq || end_q);
	assign stall    = (emit && pend_vq && !can_out) || (fin_load && !can_out);
	assign to_out   = (emit && pend_vq && can_out) || (fin_load && can_out);

	assign infix.ready     = (state_q == S_IDLE);
	assign postfix.valid   = out_vq;
	assign postfix.out_char = out_char_q;
	assign postfix.last    = out_last_q;
	assign postfix.error   = out_err_q;

	itpc_ram #(
		.WIDTH($bits(op_code_t)),
		.DEPTH(STACK_DEPTH)
	) u_stack (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(cur_op),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_comb begin
		state_d    = state_q;
		mode_d     = mode_q;
		count_d    = count_q;
		err_seen_d = err_seen_q;
		emit       = 1'b0;
		emit_char  = CH_NUL;
		emit_err   = ERR_NONE;
		ram_we     = 1'b0;
		ram_re     = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (infix.valid) begin
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				case (char_class(char_q))
					CLS_OPERATOR: begin
						emit      = 1'b1;
						emit_char = CH_SPACE;
						mode_d    = MODE_OPERATOR;
						state_d   = S_READ;
					end
					CLS_LPAREN: begin
						state_d = S_PUSH;
					end
					CLS_RPAREN: begin
						emit      = 1'b1;
						emit_char = CH_SPACE;
						mode_d    = MODE_CLOSE;
						state_d   = S_READ;
					end
					default: begin
						emit      = 1'b1;
						emit_char = char_q;
						state_d   = S_END;
					end
				endcase
			end
			S_READ: begin
				if (count_q == '0) begin
					case (mode_q)
						MODE_OPERATOR: begin
							state_d = S_PUSH;
						end
						MODE_CLOSE: begin
							if (err_seen_q == ERR_NONE) begin
								emit       = 1'b1;
								emit_err   = ERR_UNMATCHED_CLOSE;
								err_seen_d = ERR_UNMATCHED_CLOSE;
							end
							state_d = S_END;
						end
						default: begin
							state_d = S_FIN;
						end
					endcase
				end else begin
					ram_re  = 1'b1;
					state_d = S_CMP;
				end
			end
			S_CMP: begin
				case (mode_q)
					MODE_OPERATOR: begin
						if (op_level(ram_rdata) >= cur_level) begin
							emit      = 1'b1;
							emit_char = op_symbol(ram_rdata);
							count_d   = count_dec;
							state_d   = S_READ;
						end else begin
							state_d = S_PUSH;
						end
					end
					MODE_CLOSE: begin
						count_d = count_dec;
						if (ram_rdata == OP_LPAREN) begin
							state_d = S_END;
						end else begin
							emit      = 1'b1;
							emit_char = op_symbol(ram_rdata);
							state_d   = S_READ;
						end
					end
					default: begin
						count_d = count_dec;
						state_d = S_READ;
						if (ram_rdata == OP_LPAREN) begin
							if (err_seen_q == ERR_NONE) begin
								emit       = 1'b1;
								emit_err   = ERR_UNMATCHED_OPEN;
								err_seen_d = ERR_UNMATCHED_OPEN;
							end
						end else begin
							emit      = 1'b1;
							emit_char = op_symbol(ram_rdata);
						end
					end
				endcase
			end
			S_PUSH: begin
				if (count_q >= CNT_W'(STACK_DEPTH)) begin
					if (err_seen_q == ERR_NONE) begin
						emit       = 1'b1;
						emit_err   = ERR_OVERFLOW;
						err_seen_d = ERR_OVERFLOW;
					end
				end else begin
					ram_we  = 1'b1;
					count_d = count_q + CNT_W'(1);
				end
				state_d = S_END;
			end
			S_END: begin
				if (end_q && (count_q != '0)) begin
					emit      = 1'b1;
					emit_char = CH_SPACE;
					mode_d    = MODE_FLUSH;
					state_d   = S_READ;
				end else begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				if (end_q) begin
					err_seen_d = ERR_NONE;
				end
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			mode_q     <= MODE_OPERATOR;
			count_q    <= '0;
			err_seen_q <= ERR_NONE;
			end_q      <= 1'b0;
			pend_vq    <= 1'b0;
			out_vq     <= 1'b0;
		end else begin
			if (!stall) begin
				state_q    <= state_d;
				mode_q     <= mode_d;
				count_q    <= count_d;
				err_seen_q <= err_seen_d;
			end
			if (infix.valid && infix.ready) begin
				end_q <= infix.end_of_expr;
			end
			if (emit && !stall) begin
				pend_vq <= 1'b1;
			end else if (fin_load && can_out) begin
				pend_vq <= 1'b0;
			end
			if (to_out) begin
				out_vq <= 1'b1;
			end else if (postfix.ready) begin
				out_vq <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (infix.valid && infix.ready) begin
			char_q <= infix.in_char;
		end
		if (emit && !stall) begin
			pend_char_q <= emit_char;
			pend_err_q  <= emit_err;
		end
		if (to_out) begin
			out_char_q <= pend_vq ? pend_char_q : CH_NUL;
			out_err_q  <= pend_vq ? pend_err_q : ERR_NONE;
			out_last_q <= fin_load ? end_q : 1'b0;
		end
	end

	`ITPC_ASSERT_IMP(a_count_bound, 1'b1, count_q <= CNT_W'(STACK_DEPTH),
		"Stack count exceeds the stack depth.")
	`ITPC_ASSERT_IMP(a_idle_drained, state_q == S_IDLE, !pend_vq,
		"A result is still pending while the converter accepts a transaction.")
	`ITPC_ASSERT_IMP(a_end_clean, (state_q == S_IDLE) && end_q,
		(count_q == '0) && (err_seen_q == ERR_NONE),
		"Stack or error flag left set after the end of an expression.")
	`ITPC_ASSERT_IMP(a_push_room, ram_we, count_q < CNT_W'(STACK_DEPTH),
		"Stack write issued with a full stack.")
	`ITPC_ASSERT_IMP(a_err_char, out_vq && (out_err_q != ERR_NONE), out_char_q == CH_NUL,
		"An error report carries a nonzero character.")
	`ITPC_ASSERT_NXT(a_read_then_cmp, ram_re && !stall, state_q == S_CMP,
		"A stack read is not followed by the compare step.")
endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;
	import itpc_pkg::*;

	localparam int DEPTH        = STACK_DEPTH_DEF;
	localparam int DRAIN_CYCLES = 100;
	localparam int IDLE_PCT     = 8;
	localparam int MAX_PRINTS   = 40;

	typedef struct {
		logic [7:0] ch;
		logic       last;
		err_t       err;
	} postfix_char_t;

	typedef logic [7:0] char_q_t[$];

	logic clk;
	logic arst_n;

	itpc_in_if  infix_if();
	itpc_out_if postfix_if();

	infix_to_postfix_converter_core #(
		.STACK_DEPTH(DEPTH)
	) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.infix  (infix_if),
		.postfix(postfix_if)
	);

	op_code_t      op_stack [DEPTH];
	int            op_depth;
	err_t          expr_err;
	postfix_char_t step_out[$];
	postfix_char_t pending_postfix[$];

	int fail_count    = 0;
	int send_idle_pct = IDLE_PCT;
	int recv_idle_pct = IDLE_PCT;
	int hold_cycles   = 0;

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	function automatic int op_of_char(input logic [7:0] c);
		case (c)
			CH_LPAREN: return int'(OP_LPAREN);
			CH_ADD: return int'(OP_ADD);
			CH_SUB: return int'(OP_SUB);
			CH_MUL: return int'(OP_MUL);
			CH_DIV: return int'(OP_DIV);
			CH_POW: return int'(OP_POW);
			default: return -1;
		endcase
	endfunction

	function automatic level_t prec_of(input op_code_t op);
		case (op)
			OP_ADD, OP_SUB: return 2'd1;
			OP_MUL, OP_DIV: return 2'd2;
			OP_POW: return 2'd3;
			default: return 2'd0;
		endcase
	endfunction

	function automatic logic [7:0] char_of(input op_code_t op);
		case (op)
			OP_ADD: return CH_ADD;
			OP_SUB: return CH_SUB;
			OP_MUL: return CH_MUL;
			OP_DIV: return CH_DIV;
			OP_POW: return CH_POW;
			default: return CH_LPAREN;
		endcase
	endfunction

	function automatic void emit_char(input logic [7:0] ch, input err_t err);
		postfix_char_t r;
		r.ch = ch;
		r.last = 1'b0;
		r.err = err;
		step_out.push_back(r);
	endfunction

	function automatic void flag_err(input err_t err);
		if (expr_err == ERR_NONE) begin
			expr_err = err;
			emit_char(CH_NUL, err);
		end
	endfunction

	function automatic void push_op(input op_code_t op);
		if (op_depth >= DEPTH) begin
			flag_err(ERR_OVERFLOW);
		end else begin
			op_stack[op_depth] = op;
			op_depth++;
		end
	endfunction

	// One accepted character: appends the postfix characters it produces.
	function automatic void shunt_step(input logic [7:0] c, input logic e);
		int       code;
		op_code_t top;
		logic     matched;
		step_out.delete();
		code = op_of_char(c);
		if (code > int'(OP_LPAREN)) begin
			emit_char(CH_SPACE, ERR_NONE);
			while (op_depth > 0 &&
					prec_of(op_stack[op_depth - 1]) >= prec_of(op_code_t'(code))) begin
				op_depth--;
				emit_char(char_of(op_stack[op_depth]), ERR_NONE);
			end
			push_op(op_code_t'(code));
		end else if (code == int'(OP_LPAREN)) begin
			push_op(OP_LPAREN);
		end else if (c == CH_RPAREN) begin
			matched = 1'b0;
			emit_char(CH_SPACE, ERR_NONE);
			while (op_depth > 0 && !matched) begin
				op_depth--;
				top = op_stack[op_depth];
				if (top == OP_LPAREN) begin
					matched = 1'b1;
				end else begin
					emit_char(char_of(top), ERR_NONE);
				end
			end
			if (!matched) begin
				flag_err(ERR_UNMATCHED_CLOSE);
			end
		end else begin
			emit_char(c, ERR_NONE);
		end
		if (e) begin
			if (op_depth > 0) begin
				emit_char(CH_SPACE, ERR_NONE);
			end
			while (op_depth > 0) begin
				op_depth--;
				top = op_stack[op_depth];
				if (top == OP_LPAREN) begin
					flag_err(ERR_UNMATCHED_OPEN);
				end else begin
					emit_char(char_of(top), ERR_NONE);
				end
			end
			expr_err = ERR_NONE;
			if (step_out.size() == 0) begin
				emit_char(CH_NUL, ERR_NONE);
			end
			step_out[step_out.size() - 1].last = 1'b1;
		end
		foreach (step_out[i]) begin
			pending_postfix.push_back(step_out[i]);
		end
	endfunction

	task automatic report_mismatch(input string what, input postfix_char_t want,
			input postfix_char_t got);
		fail_count++;
		if (fail_count <= MAX_PRINTS) begin
			$display("%0t %s: expected char %h last %b error %0d, got char %h last %b error %0d",
				$realtime, what, want.ch, want.last, want.err, got.ch, got.last, got.err);
		end
	endtask

	always @(posedge clk) begin
		postfix_char_t got;
		postfix_char_t want;
		if (arst_n && postfix_if.valid && postfix_if.ready) begin
			got.ch = postfix_if.out_char;
			got.last = postfix_if.last;
			got.err = postfix_if.error;
			if (pending_postfix.size() == 0) begin
				want.ch = CH_NUL;
				want.last = 1'b0;
				want.err = ERR_NONE;
				report_mismatch("unexpected transaction", want, got);
			end else begin
				want = pending_postfix.pop_front();
				if (got.ch !== want.ch || got.last !== want.last || got.err !== want.err) begin
					report_mismatch("mismatch", want, got);
				end
			end
		end
	end

	initial begin
		postfix_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				postfix_if.ready <= 1'b0;
				hold_cycles--;
			end else begin
				postfix_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
			end
		end
	end

	task automatic send_char(input logic [7:0] c, input logic e);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			infix_if.valid <= 1'b0;
			@(negedge clk);
		end
		infix_if.valid <= 1'b1;
		infix_if.in_char <= c;
		infix_if.end_of_expr <= e;
		@(posedge clk);
		while (!infix_if.ready) begin
			@(posedge clk);
		end
		shunt_step(c, e);
	endtask

	task automatic send_expr(input char_q_t s);
		foreach (s[i]) begin
			send_char(s[i], i == s.size() - 1);
		end
	endtask

	task automatic wait_drain();
		@(negedge clk);
		infix_if.valid <= 1'b0;
		wait (pending_postfix.size() == 0);
	endtask

	function automatic logic [7:0] rand_operand();
		logic [7:0] c;
		do begin
			c = 8'($urandom_range(0, 255));
		end while (op_of_char(c) >= 0 || c == CH_RPAREN);
		return c;
	endfunction

	function automatic logic [7:0] rand_operator();
		case ($urandom_range(0, 4))
			0: return CH_ADD;
			1: return CH_SUB;
			2: return CH_MUL;
			3: return CH_DIV;
			default: return CH_POW;
		endcase
	endfunction

	function automatic char_q_t build_expr();
		char_q_t s;
		int      depth;
		int      terms;
		logic    want_operand;
		depth = 0;
		terms = $urandom_range(1, 7);
		want_operand = 1'b1;
		while (want_operand || terms > 0 || depth > 0) begin
			if (want_operand) begin
				if (depth < 5 && $urandom_range(0, 3) == 0) begin
					s.push_back(CH_LPAREN);
					depth++;
				end else begin
					s.push_back(rand_operand());
					want_operand = 1'b0;
					terms--;
				end
			end else if (depth > 0 && (terms == 0 || $urandom_range(0, 2) == 0)) begin
				s.push_back(CH_RPAREN);
				depth--;
			end else begin
				s.push_back(rand_operator());
				want_operand = 1'b1;
			end
		end
		return s;
	endfunction

	// A full stack of open parentheses and a multiply, then a power that cannot be pushed.
	task automatic test_overflow();
		char_q_t s;
		repeat (DEPTH - 1) s.push_back(CH_LPAREN);
		s.push_back(CH_MUL);
		s.push_back(CH_POW);
		send_expr(s);
		wait_drain();
	endtask

	task automatic test_char_extremes();
		char_q_t s;
		s = '{8'h00, CH_SUB, 8'hFF};
		send_expr(s);
		wait_drain();
	endtask

	task automatic test_unmatched_close();
		char_q_t s;
		s = '{"a", CH_ADD, "b", CH_RPAREN};
		send_expr(s);
		wait_drain();
	endtask

	task automatic test_unmatched_open();
		char_q_t s;
		s = '{CH_LPAREN, "a", CH_DIV, "b"};
		send_expr(s);
		wait_drain();
	endtask

	// The receiver stops long enough for the converter to stall its input.
	task automatic test_backpressure();
		hold_cycles = 300;
		repeat (3) send_expr(build_expr());
		wait_drain();
	endtask

	task automatic test_random(input int n_items);
		char_q_t s;
		int      sent;
		int      pick;
		int      pos;
		sent = 0;
		while (sent < n_items) begin
			if (sent >= n_items / 3 && sent < 2 * n_items / 3) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end else begin
				send_idle_pct = IDLE_PCT;
				recv_idle_pct = IDLE_PCT;
			end
			pick = $urandom_range(0, 9);
			if (pick == 0) begin
				repeat ($urandom_range(1, 4)) begin
					send_char(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
					sent++;
				end
			end else begin
				s = build_expr();
				if (pick == 1) begin
					pos = $urandom_range(0, s.size() - 1);
					case ($urandom_range(0, 3))
						0: s[pos] = CH_LPAREN;
						1: s[pos] = CH_RPAREN;
						2: s[pos] = 8'($urandom_range(0, 255));
						default: if (s.size() > 1) s.delete(pos);
					endcase
				end
				send_expr(s);
				sent += s.size();
			end
		end
		wait_drain();
	endtask

	initial begin
		infix_if.valid = 1'b0;
		infix_if.in_char = CH_NUL;
		infix_if.end_of_expr = 1'b0;
		arst_n = 1'b0;
		op_depth = 0;
		expr_err = ERR_NONE;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_overflow();
		test_char_extremes();
		test_unmatched_close();
		test_unmatched_open();
		test_backpressure();
		test_random(300);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("Verification failed");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/itpc_pkg.sv
rtl/itpc_in_if.sv
rtl/itpc_out_if.sv
rtl/itpc_ram.sv
rtl/infix_to_postfix_converter_core.sv
sim/tb.sv
